// ----- rtl/core/bbc_pkg.sv -----
// Shared types and constants for the block buffer cache unit.
package bbc_pkg;

  localparam int unsigned EntriesDef = 64;
  localparam int unsigned RefBitsDef = 16;

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_ALLOC     = 3'd1,
    ST_ZERO      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EXHAUSTED = 3'd4,
    ST_REL_HELD  = 3'd5,
    ST_REL_IDLE  = 3'd6
  } status_e;

  typedef struct packed {
    logic load;
    logic start_pass;
    logic decide;
    logic sweep;
  } bbc_cmd_t;

  typedef struct packed {
    logic pass_done;
    logic need_write;
  } bbc_sts_t;

endpackage

// ----- rtl/core/refcounted_block_buffer_cache_unit.sv -----
// Top level of the reference-counted block buffer cache tag and replacement unit.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+----
//  request | in_valid_i/in_ready_o, cmd_i .. release_slot_i   | in
//  result  | out_valid_o/out_ready_i, status_o .. ref_count_o  | out
//
// Each word runs a tag scan through the entry memory read port and the decision, then
// the result handshake; ready rises again once the result is taken. A change to an
// entry or the idle ranks adds a rewrite pass over every entry before the result.
// Reset clears valid bits, idle count and control; entry memory needs no clearing.
// One word is in flight; a stalled result holds and blocks the next request.
module refcounted_block_buffer_cache_unit #(
  parameter int unsigned ENTRIES  = bbc_pkg::EntriesDef,
  parameter int unsigned REF_BITS = bbc_pkg::RefBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] file_id_i,
  input  logic [31:0] block_index_i,
  input  logic [31:0] device_address_i,
  input  logic        address_valid_i,
  input  logic [5:0]  release_slot_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [5:0]  slot_o,
  output logic [31:0] fill_address_o,
  output logic [15:0] ref_count_o
);
  import bbc_pkg::*;

  bbc_cmd_t cmd;
  bbc_sts_t sts;

  bbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bbc_dpath #(
    .ENTRIES  (ENTRIES),
    .REF_BITS (REF_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cmd_in_i         (cmd_i),
    .file_id_i        (file_id_i),
    .block_index_i    (block_index_i),
    .device_address_i (device_address_i),
    .address_valid_i  (address_valid_i),
    .release_slot_i   (release_slot_i),
    .status_o         (status_o),
    .slot_o           (slot_o),
    .fill_address_o   (fill_address_o),
    .ref_count_o      (ref_count_o)
  );

endmodule

// ----- rtl/core/bbc_ctrl.sv -----
// Sequencer for the scan, decide and update passes of the buffer cache.
module bbc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  bbc_pkg::bbc_sts_t sts_i,
  output bbc_pkg::bbc_cmd_t cmd_o
);
  import bbc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SWEEP,
    S_OUT
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   accept;

  assign accept      = in_valid_i & in_ready_q;
  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = accept;
    cmd_o.start_pass = accept | ((state_q == S_DECIDE) & sts_i.need_write);
    cmd_o.decide     = (state_q == S_DECIDE);
    cmd_o.sweep      = (state_q == S_SWEEP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q    <= S_SCAN;
            in_ready_q <= 1'b0;
          end
        end
        S_SCAN: begin
          if (sts_i.pass_done) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (sts_i.need_write) begin
            state_q <= S_SWEEP;
          end else begin
            state_q     <= S_OUT;
            out_valid_q <= 1'b1;
          end
        end
        S_SWEEP: begin
          if (sts_i.pass_done) begin
            state_q     <= S_OUT;
            out_valid_q <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/bbc_dpath.sv -----
// Datapath: entry memory, valid bits, scan accumulators and rank update.
module bbc_dpath #(
  parameter int unsigned ENTRIES  = bbc_pkg::EntriesDef,
  parameter int unsigned REF_BITS = bbc_pkg::RefBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bbc_pkg::bbc_cmd_t cmd_i,
  output bbc_pkg::bbc_sts_t sts_o,
  input  logic              cmd_in_i,
  input  logic [31:0]       file_id_i,
  input  logic [31:0]       block_index_i,
  input  logic [31:0]       device_address_i,
  input  logic              address_valid_i,
  input  logic [5:0]        release_slot_i,
  output logic [2:0]        status_o,
  output logic [5:0]        slot_o,
  output logic [31:0]       fill_address_o,
  output logic [15:0]       ref_count_o
);
  import bbc_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned TW = IW + 1;

  typedef struct packed {
    logic [31:0]       file;
    logic [31:0]       index;
    logic [31:0]       addr;
    logic [REF_BITS-1:0] refs;
    logic [IW-1:0]     rank;
  } row_t;

  typedef enum logic [1:0] {
    M_NONE,
    M_INC,
    M_DEC
  } mode_e;

  row_t mem [ENTRIES];
  row_t rd_q;

  logic              cmd_q, av_q;
  logic [31:0]       fid_q, bix_q, dev_q;
  logic [5:0]        rslot_q;

  logic [IW-1:0]     ridx_q, pidx_q;
  logic              issuing_q, pv_q;
  logic [ENTRIES-1:0] valid_q;
  logic [TW-1:0]     total_q;

  logic              hit_q, inv_q, old_q;
  logic [IW-1:0]     hit_idx_q, inv_idx_q, old_idx_q;
  row_t              hit_row_q, rel_row_q;
  logic [IW-1:0]     old_rank_q;

  mode_e             mode_q, mode_d;
  logic [IW-1:0]     tgt_q, tgt_d, thr_q, thr_d;
  row_t              trow_q, trow_d;

  logic              need_write, set_valid;
  logic [TW-1:0]     total_d;
  logic [2:0]        res_st_d;
  logic [5:0]        res_slot_d;
  logic [31:0]       res_fill_d;
  logic [15:0]       res_refs_d;

  logic [IW-1:0]     rel_idx;
  logic              rel_ok;
  logic [REF_BITS-1:0] dec_refs, inc_refs;
  logic              ent_valid, ent_idle;
  row_t              wrow;
  logic              wr_en;

  function automatic logic [15:0] sat16(input logic [REF_BITS-1:0] r);
    logic [31:0] r32;
    r32 = 32'(r);
    return (r32 > 32'd65535) ? 16'hFFFF : r32[15:0];
  endfunction

  assign rel_idx   = IW'(rslot_q);
  assign ent_valid = valid_q[pidx_q];
  assign ent_idle  = ent_valid && (rd_q.refs == '0);

  assign sts_o.pass_done  = pv_q && (pidx_q == IW'(ENTRIES - 1));
  assign sts_o.need_write = need_write;

  // read pointer and memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ridx_q    <= '0;
      pidx_q    <= '0;
      issuing_q <= 1'b0;
      pv_q      <= 1'b0;
    end else begin
      pv_q   <= issuing_q;
      pidx_q <= ridx_q;
      if (cmd_i.start_pass) begin
        ridx_q    <= '0;
        issuing_q <= 1'b1;
      end else if (issuing_q) begin
        if (ridx_q == IW'(ENTRIES - 1)) issuing_q <= 1'b0;
        else ridx_q <= ridx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[pidx_q] <= wrow;
    rd_q <= mem[ridx_q];
  end

  // sweep rewrite
  always_comb begin
    wr_en = pv_q && cmd_i.sweep;
    wrow  = rd_q;
    if (pidx_q == tgt_q) begin
      wrow = trow_q;
    end else if (ent_idle) begin
      unique case (mode_q)
        M_INC:   wrow.rank = rd_q.rank + 1'b1;
        M_DEC:   if (rd_q.rank > thr_q) wrow.rank = rd_q.rank - 1'b1;
        default: wrow = rd_q;
      endcase
    end
  end

  // input capture and scan accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      inv_q <= 1'b0;
      old_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q <= 1'b0;
      inv_q <= 1'b0;
      old_q <= 1'b0;
    end else if (pv_q && !cmd_i.sweep) begin
      if (!hit_q && ent_valid && rd_q.file == fid_q && rd_q.index == bix_q) hit_q <= 1'b1;
      if (!ent_valid) inv_q <= 1'b1;
      if (!old_q && ent_idle && total_q != '0 && TW'(rd_q.rank) == total_q - 1'b1)
        old_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= cmd_in_i;
      fid_q   <= file_id_i;
      bix_q   <= block_index_i;
      dev_q   <= device_address_i;
      av_q    <= address_valid_i;
      rslot_q <= release_slot_i;
    end else if (pv_q && !cmd_i.sweep) begin
      if (!hit_q && ent_valid && rd_q.file == fid_q && rd_q.index == bix_q) begin
        hit_idx_q <= pidx_q;
        hit_row_q <= rd_q;
      end
      if (!ent_valid) inv_idx_q <= pidx_q;
      if (!old_q && ent_idle && total_q != '0 && TW'(rd_q.rank) == total_q - 1'b1) begin
        old_idx_q  <= pidx_q;
        old_rank_q <= rd_q.rank;
      end
      if (pidx_q == rel_idx) rel_row_q <= rd_q;
    end
  end

  // decision
  always_comb begin
    rel_ok     = (32'(rslot_q) < 32'(ENTRIES)) && valid_q[rel_idx] && (rel_row_q.refs != '0);
    dec_refs   = rel_row_q.refs - 1'b1;
    inc_refs   = (hit_row_q.refs != '1) ? hit_row_q.refs + 1'b1 : hit_row_q.refs;
    need_write = 1'b0;
    set_valid  = 1'b0;
    mode_d     = M_NONE;
    tgt_d      = '0;
    thr_d      = '0;
    trow_d     = '0;
    total_d    = total_q;
    res_st_d   = ST_EXHAUSTED;
    res_slot_d = '0;
    res_fill_d = '0;
    res_refs_d = '0;
    if (cmd_q == CMD_RELEASE) begin
      res_st_d   = ST_REL_IDLE;
      res_slot_d = rslot_q;
      if (rel_ok) begin
        need_write  = 1'b1;
        tgt_d       = rel_idx;
        trow_d      = rel_row_q;
        trow_d.refs = dec_refs;
        if (dec_refs == '0) begin
          mode_d      = M_INC;
          trow_d.rank = '0;
          total_d     = total_q + 1'b1;
        end else begin
          res_st_d   = ST_REL_HELD;
          res_refs_d = sat16(dec_refs);
        end
      end
    end else if (hit_q) begin
      need_write  = 1'b1;
      tgt_d       = hit_idx_q;
      trow_d      = hit_row_q;
      trow_d.refs = inc_refs;
      if (hit_row_q.refs == '0) begin
        mode_d      = M_DEC;
        thr_d       = hit_row_q.rank;
        trow_d.rank = '0;
        total_d     = total_q - 1'b1;
      end
      res_st_d   = ST_HIT;
      res_slot_d = 6'(hit_idx_q);
      res_fill_d = hit_row_q.addr;
      res_refs_d = sat16(inc_refs);
    end else if (!av_q) begin
      res_st_d = ST_NOT_FOUND;
    end else if (dev_q == '0) begin
      res_st_d = ST_ZERO;
    end else if (inv_q || old_q) begin
      need_write  = 1'b1;
      trow_d.file  = fid_q;
      trow_d.index = bix_q;
      trow_d.addr  = dev_q;
      trow_d.refs  = REF_BITS'(1);
      trow_d.rank  = '0;
      if (inv_q) begin
        tgt_d     = inv_idx_q;
        set_valid = 1'b1;
      end else begin
        tgt_d   = old_idx_q;
        mode_d  = M_DEC;
        thr_d   = old_rank_q;
        total_d = total_q - 1'b1;
      end
      res_st_d   = ST_ALLOC;
      res_slot_d = 6'(tgt_d);
      res_fill_d = dev_q;
      res_refs_d = 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      total_q <= '0;
      mode_q  <= M_NONE;
      tgt_q   <= '0;
    end else if (cmd_i.decide) begin
      if (set_valid) valid_q[tgt_d] <= 1'b1;
      total_q <= total_d;
      mode_q  <= mode_d;
      tgt_q   <= tgt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      thr_q          <= thr_d;
      trow_q         <= trow_d;
      status_o       <= res_st_d;
      slot_o         <= res_slot_d;
      fill_address_o <= res_fill_d;
      ref_count_o    <= res_refs_d;
    end
  end

endmodule

// ----- bench/bbc_checker.sv -----
// Result checker for the block buffer cache unit: models the slot pool and compares each result.
`timescale 1ns / 100ps
module bbc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        cmd_i,
  input  logic [31:0] file_id_i,
  input  logic [31:0] block_index_i,
  input  logic [31:0] device_address_i,
  input  logic        address_valid_i,
  input  logic [5:0]  release_slot_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  status_i,
  input  logic [5:0]  slot_i,
  input  logic [31:0] fill_address_i,
  input  logic [15:0] ref_count_i,
  output int          fail_count_o,
  output int          pending_o
);
  import bbc_pkg::*;

  localparam int Slots = 64;
  localparam logic [15:0] RefMax = 16'hFFFF;

  typedef struct packed {
    status_e     status;
    logic [5:0]  slot;
    logic [31:0] fill_address;
    logic [15:0] ref_count;
  } cache_result_t;

  logic        slot_used [Slots];
  logic [31:0] slot_file [Slots];
  logic [31:0] slot_block [Slots];
  logic [31:0] slot_addr [Slots];
  logic [15:0] slot_refs [Slots];
  int          slot_rank [Slots];
  int          idle_cnt;

  cache_result_t expected_results[$];
  int mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = expected_results.size();

  function automatic bit slot_idle(int i);
    return slot_used[i] && slot_refs[i] == 0;
  endfunction

  function automatic void drop_idle(int s);
    for (int i = 0; i < Slots; i++)
      if (i != s && slot_idle(i) && slot_rank[i] > slot_rank[s]) slot_rank[i]--;
    slot_rank[s] = 0;
    if (idle_cnt > 0) idle_cnt--;
  endfunction

  function automatic void push_idle(int s);
    for (int i = 0; i < Slots; i++)
      if (i != s && slot_idle(i)) slot_rank[i]++;
    slot_rank[s] = 0;
    idle_cnt++;
  endfunction

  function automatic cache_result_t lookup_or_release(logic cmd, logic [31:0] fid,
      logic [31:0] bix, logic [31:0] dev, logic avalid, logic [5:0] rslot);
    cache_result_t r;
    int victim;
    r = '{status: ST_REL_IDLE, slot: rslot, fill_address: '0, ref_count: '0};
    if (cmd == CMD_RELEASE) begin
      if (!slot_used[rslot] || slot_refs[rslot] == 0) return r;
      slot_refs[rslot]--;
      if (slot_refs[rslot] == 0) begin
        push_idle(rslot);
      end else begin
        r.status    = ST_REL_HELD;
        r.ref_count = slot_refs[rslot];
      end
      return r;
    end
    for (int i = 0; i < Slots; i++) begin
      if (slot_used[i] && slot_file[i] == fid && slot_block[i] == bix) begin
        if (slot_refs[i] == 0) drop_idle(i);
        if (slot_refs[i] < RefMax) slot_refs[i]++;
        return '{status: ST_HIT, slot: i[5:0], fill_address: slot_addr[i],
                 ref_count: slot_refs[i]};
      end
    end
    r = '{status: ST_NOT_FOUND, slot: '0, fill_address: '0, ref_count: '0};
    if (!avalid) return r;
    r.status = ST_ZERO;
    if (dev == 0) return r;
    victim = -1;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        victim = i;
        break;
      end
    end
    if (victim < 0 && idle_cnt > 0) begin
      for (int i = 0; i < Slots; i++) begin
        if (slot_idle(i) && slot_rank[i] == idle_cnt - 1) begin
          victim = i;
          break;
        end
      end
      if (victim >= 0) drop_idle(victim);
    end
    r.status = ST_EXHAUSTED;
    if (victim < 0) return r;
    slot_used[victim]  = 1'b1;
    slot_file[victim]  = fid;
    slot_block[victim] = bix;
    slot_addr[victim]  = dev;
    slot_refs[victim]  = 16'd1;
    slot_rank[victim]  = 0;
    return '{status: ST_ALLOC, slot: victim[5:0], fill_address: dev, ref_count: 16'd1};
  endfunction

  initial begin
    for (int i = 0; i < Slots; i++) begin
      slot_used[i] = 1'b0;
      slot_refs[i] = '0;
      slot_rank[i] = 0;
    end
    idle_cnt   = 0;
    mismatches = 0;
  end

  always @(posedge clk_i) begin
    cache_result_t got, want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        expected_results.push_back(lookup_or_release(cmd_i, file_id_i, block_index_i,
            device_address_i, address_valid_i, release_slot_i));
      if (out_valid_i && out_ready_i) begin
        got = '{status: status_e'(status_i), slot: slot_i, fill_address: fill_address_i,
                ref_count: ref_count_i};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.fill_address !== want.fill_address ||
              got.ref_count !== want.ref_count) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
          end
        end
      end
    end
  end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the block buffer cache unit: reset, request stimulus and verdict.
`timescale 1ns / 100ps
module tb;
  import bbc_pkg::*;

  logic        clk, rst_n;
  logic        in_valid, in_ready, cmd, address_valid;
  logic [31:0] file_id, block_index, device_address;
  logic [5:0]  release_slot;
  logic        out_valid, out_ready;
  logic [2:0]  status;
  logic [5:0]  slot;
  logic [31:0] fill_address;
  logic [15:0] ref_count;
  int          fail_count, pending;
  int          send_idle_pct, recv_idle_pct, acquire_pct;

  refcounted_block_buffer_cache_unit uut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(cmd), .file_id_i(file_id), .block_index_i(block_index),
    .device_address_i(device_address), .address_valid_i(address_valid),
    .release_slot_i(release_slot), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .slot_o(slot), .fill_address_o(fill_address),
    .ref_count_o(ref_count)
  );

  bbc_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .cmd_i(cmd), .file_id_i(file_id), .block_index_i(block_index),
    .device_address_i(device_address), .address_valid_i(address_valid),
    .release_slot_i(release_slot), .out_valid_i(out_valid), .out_ready_i(out_ready),
    .status_i(status), .slot_i(slot), .fill_address_i(fill_address),
    .ref_count_i(ref_count), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(negedge clk) out_ready <= $urandom_range(99) >= recv_idle_pct;

  task automatic send_word(logic c, logic [31:0] f, logic [31:0] b, logic [31:0] d,
                           logic av, logic [5:0] rs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    cmd            <= c;
    file_id        <= f;
    block_index    <= b;
    device_address <= d;
    address_valid  <= av;
    release_slot   <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_word();
    logic [31:0] f, b, d;
    f = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(3);
    b = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(47);
    if ($urandom_range(15) == 0) f = 32'hFFFF_FFFF;
    d = ($urandom_range(19) == 0) ? 32'd0 : $urandom();
    if ($urandom_range(99) < acquire_pct)
      send_word(CMD_ACQUIRE, f, b, d, $urandom_range(19) != 0, 6'($urandom()));
    else
      send_word(CMD_RELEASE, $urandom(), $urandom(), $urandom(), 1'($urandom_range(1)),
                6'($urandom_range(63)));
  endtask

  initial begin
    in_valid = 1'b0; cmd = CMD_ACQUIRE; file_id = '0; block_index = '0;
    device_address = '0; address_valid = 1'b0; release_slot = '0; out_ready = 1'b0;
    send_idle_pct = 9; recv_idle_pct = 67; acquire_pct = 60;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_word(CMD_RELEASE, '0, '0, '0, 1'b0, 6'd0);
    send_word(CMD_RELEASE, '1, '1, '1, 1'b1, 6'd63);
    send_word(CMD_ACQUIRE, '0, '0, 32'd5, 1'b0, '0);
    send_word(CMD_ACQUIRE, '0, '0, 32'd0, 1'b0, '0);
    send_word(CMD_ACQUIRE, '0, '0, 32'd0, 1'b1, '0);
    send_word(CMD_ACQUIRE, '0, '0, 32'd1, 1'b1, '0);
    send_word(CMD_ACQUIRE, '1, '1, '1, 1'b1, '1);
    send_word(CMD_ACQUIRE, '0, '0, 32'd9, 1'b0, '0);
    send_word(CMD_ACQUIRE, '1, '1, '0, 1'b0, '0);
    send_word(CMD_RELEASE, '0, '0, '0, 1'b0, 6'd63);
    send_word(CMD_RELEASE, '0, '0, '0, 1'b0, 6'd63);
    send_word(CMD_RELEASE, '0, '0, '0, 1'b0, 6'd63);
    send_word(CMD_RELEASE, '0, '0, '0, 1'b0, 6'd62);
    send_word(CMD_ACQUIRE, '1, '1, 32'd3, 1'b1, '0);
    send_word(CMD_RELEASE, '0, '0, '0, 1'b0, 6'd62);
    send_word(CMD_RELEASE, '0, '0, '0, 1'b0, 6'd17);

    for (int i = 0; i < 90; i++) begin
      acquire_pct = 97;
      random_word();
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    for (int i = 0; i < 510; i++) begin
      acquire_pct = (i % 170 < 100) ? 55 : 85;
      random_word();
    end
    send_idle_pct = 67; recv_idle_pct = 9;
    for (int i = 0; i < 550; i++) begin
      acquire_pct = (i % 150 < 70) ? 45 : 80;
      random_word();
    end
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < 550; i++) begin
      acquire_pct = (i % 200 < 120) ? 60 : 90;
      random_word();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/bbc_pkg.sv
rtl/core/bbc_ctrl.sv
rtl/core/bbc_dpath.sv
rtl/core/refcounted_block_buffer_cache_unit.sv
bench/bbc_checker.sv
bench/tb.sv
